// ===== hw/rtl/chse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chse_pkg
// Shared widths, register indexes and helpers for the cubic Hermite
// segment evaluator.
// ----------------------------------------------------------------------------
package chse_pkg;

	// polynomial order of the segment
	localparam int POLY_ORDER = 3;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_VEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_POS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_VEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd4;

	// field widths
	localparam int T_W   = 17;  // local time, signed
	localparam int DUR_W = 16;  // duration ticks
	localparam int VAL_W = 32;  // Q16.16 values

	// datapath widths
	localparam int CW   = 51;            // quad / cubic coefficients, signed
	localparam int MW   = 48;            // time-power multiplicands, unsigned
	localparam int CHK  = 16;            // multiplicand chunk
	localparam int NCH  = MW / CHK;      // chunks per multiplicand
	localparam int PW   = CW + CHK + 1;  // partial product, signed
	localparam int NW   = 100;           // signed numerator
	localparam int NMW  = NW - 1;        // numerator magnitude
	localparam int DW   = 48;            // divisor T^3
	localparam int QW   = 50;            // quotient bits kept before clamp
	localparam int BW   = 50;            // position base, signed
	localparam int RW   = 53;            // pre-saturation result, signed
	localparam int NTERM = 6;            // coefficient products
	localparam int NRES  = 3;            // pos, vel, acc
	localparam int DIV_LAT = QW + 1;     // divider register stages

	typedef struct packed {
		logic                  err;
		logic [NRES-1:0]       neg;
		logic signed [BW-1:0]  base;
	} sband_t;

	localparam logic signed [RW-1:0] SAT_HI = RW'(64'sd2147483647);
	localparam logic signed [RW-1:0] SAT_LO = RW'(-64'sd2147483648);

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [RW-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[VAL_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[VAL_W-1:0];
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/chse_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chse_div
// Pipelined restoring divider, one quotient bit per stage. Flags when the
// quotient would reach 2^QUO_W.
// ----------------------------------------------------------------------------
module chse_div #(
	parameter int NUM_W = chse_pkg::NMW,
	parameter int DEN_W = chse_pkg::DW,
	parameter int QUO_W = chse_pkg::QW
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             sat
);
	localparam int HI_W  = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [DEN_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] low_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic             sat_s [0:QUO_W];

	logic [HI_W-1:0] num_hi;
	logic            hi_ge;

	assign num_hi = num[NUM_W-1:QUO_W];
	assign hi_ge  = CMP_W'(num_hi) >= CMP_W'(den);

	// entry: upper part decides saturation, lower bits shift in later
	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0] <= hi_ge;
			rem_s[0] <= DEN_W'(num_hi);
			low_s[0] <= num[QUO_W-1:0];
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
		logic [DEN_W:0] cat;
		logic           ge;
		logic [DEN_W:0] dif;

		assign cat = {rem_s[k-1], low_s[k-1][QUO_W-1]};
		assign ge  = cat >= {1'b0, den};
		assign dif = cat - {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? dif[DEN_W-1:0] : cat[DEN_W-1:0];
				low_s[k] <= {low_s[k-1][QUO_W-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge};
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign quo = quo_s[QUO_W];
	assign sat = sat_s[QUO_W];

endmodule
`default_nettype wire

// ===== hw/rtl/cubic_hermite_segment_eval_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle while out_stall holds no result; the 50-stage divider
// (one quotient bit per stage, three in parallel for pos/vel/acc) sets the depth.
// The whole pipeline holds while a result waits under out_stall.
// Reset: registers return to zero, duration to one; after any write the coefficients
// are rederived into q_q/k_q, and T^3 through t2_q into t3_q.
// ----------------------------------------------------------------------------
// cubic_hermite_segment_eval_top
// One axis of a cubic Hermite segment: position, velocity and acceleration
// at a local time, Q16.16, rounded and saturated.
// ----------------------------------------------------------------------------
module cubic_hermite_segment_eval_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [chse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [chse_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [chse_pkg::T_W-1:0]      t_local,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [chse_pkg::VAL_W-1:0]    pos_out,
	output logic signed [chse_pkg::VAL_W-1:0]    vel_out,
	output logic signed [chse_pkg::VAL_W-1:0]    acc_out,
	output logic                                 time_error
);
	import chse_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [VAL_W-1:0] sp_q, sv_q, ep_q, ev_q;
	logic [DUR_W-1:0]        dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			sv_q  <= '0;
			ep_q  <= '0;
			ev_q  <= '0;
			dur_q <= DUR_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_POS: sp_q <= $signed(cfg_data[VAL_W-1:0]);
				REG_START_VEL: sv_q <= $signed(cfg_data[VAL_W-1:0]);
				REG_END_POS:   ep_q <= $signed(cfg_data[VAL_W-1:0]);
				REG_END_VEL:   ev_q <= $signed(cfg_data[VAL_W-1:0]);
				REG_DURATION: begin
					// zero duration is taken as one tick
					dur_q <= (cfg_data[DUR_W-1:0] == '0) ? DUR_W'(1) : cfg_data[DUR_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Coefficient derivation, refreshed every cycle from the registers.
	//   Q = -(3*(sp-ep) + T*(2*sv+ev)),  K = 2*(sp-ep) + T*(sv+ev)
	// ------------------------------------------------------------------
	logic signed [VAL_W:0]   diff;
	logic signed [VAL_W+1:0] vq;
	logic signed [VAL_W:0]   vk;
	logic signed [DUR_W:0]   dur_sg;
	logic signed [CW-1:0]    qp, kp, q_d, k_d;
	logic signed [CW-1:0]    q_q, k_q;
	logic [2*DUR_W-1:0]      t2_q;
	logic [DW-1:0]           t3_q;

	always_comb begin
		diff   = (VAL_W+1)'(sp_q) - (VAL_W+1)'(ep_q);
		vq     = (VAL_W+2)'(sv_q) + (VAL_W+2)'(sv_q) + (VAL_W+2)'(ev_q);
		vk     = (VAL_W+1)'(sv_q) + (VAL_W+1)'(ev_q);
		dur_sg = $signed({1'b0, dur_q});
		qp     = dur_sg * vq;
		kp     = dur_sg * vk;
		q_d    = -(CW'(diff) + CW'(diff) + CW'(diff) + qp);
		k_d    = CW'(diff) + CW'(diff) + kp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q  <= '0;
			k_q  <= '0;
			t2_q <= (2*DUR_W)'(1);
			t3_q <= DW'(1);
		end else begin
			q_q  <= q_d;
			k_q  <= k_d;
			t2_q <= dur_q * dur_q;
			t3_q <= DW'(t2_q) * DW'(dur_q);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline enable: everything moves unless a finished result is held
	// ------------------------------------------------------------------
	logic en;
	logic out_valid_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// s1: t^2, t*T and sv*t
	// ------------------------------------------------------------------
	logic                    vld_s1;
	logic                    err_s1;
	logic [DUR_W-1:0]        t_s1;
	logic [2*DUR_W-1:0]      tt_s1, tT_s1;
	logic signed [VAL_W+DUR_W:0] svt_s1;
	logic [DUR_W-1:0]        t_in;

	assign t_in = t_local[DUR_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1 <= t_local[T_W-1];
			t_s1   <= t_in;
			tt_s1  <= t_in * t_in;
			tT_s1  <= t_in * dur_q;
			svt_s1 <= sv_q * $signed({1'b0, t_in});
		end
	end

	// ------------------------------------------------------------------
	// s2: multiplicands for the six coefficient products, position base
	//   Q terms: t^2*T, 2*t*T, 2*T      K terms: t^3, 3*t^2, 6*t
	// ------------------------------------------------------------------
	logic               vld_s2;
	logic               err_s2;
	logic [MW-1:0]      m_s2 [0:NTERM-1];
	logic signed [BW-1:0] base_s2;
	logic [MW-1:0]      m_d  [0:NTERM-1];

	always_comb begin
		m_d[0] = MW'(tt_s1) * MW'(dur_q);
		m_d[1] = MW'(tt_s1) * MW'(t_s1);
		m_d[2] = MW'({tT_s1, 1'b0});
		m_d[3] = MW'(tt_s1) * MW'(POLY_ORDER);
		m_d[4] = MW'({dur_q, 1'b0});
		m_d[5] = MW'(t_s1) * MW'(POLY_ORDER * (POLY_ORDER - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s2  <= err_s1;
			base_s2 <= BW'(sp_q) + BW'(svt_s1);
			for (int i = 0; i < NTERM; i++) begin
				m_s2[i] <= m_d[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// s3: partial products, coefficient times 16-bit chunks
	// ------------------------------------------------------------------
	logic               vld_s3;
	logic               err_s3;
	logic signed [BW-1:0] base_s3;
	logic signed [PW-1:0] pp_s3 [0:NTERM-1][0:NCH-1];

	for (genvar i = 0; i < NTERM; i++) begin : g_pp
		logic signed [CW-1:0] coef;
		assign coef = ((i % 2) == 0) ? q_q : k_q;
		for (genvar j = 0; j < NCH; j++) begin : g_chunk
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s3[i][j] <= coef * $signed({1'b0, m_s2[i][CHK*j +: CHK]});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s3  <= err_s2;
			base_s3 <= base_s2;
		end
	end

	// ------------------------------------------------------------------
	// s4: recombine partials into full products
	// ------------------------------------------------------------------
	logic               vld_s4;
	logic               err_s4;
	logic signed [BW-1:0] base_s4;
	logic signed [NW-1:0] term_s4 [0:NTERM-1];

	always_ff @(posedge clk) begin
		if (en) begin
			err_s4  <= err_s3;
			base_s4 <= base_s3;
			for (int i = 0; i < NTERM; i++) begin
				term_s4[i] <= NW'(pp_s3[i][0]) + (NW'(pp_s3[i][1]) <<< CHK)
					+ (NW'(pp_s3[i][2]) <<< (2*CHK));
			end
		end
	end

	// ------------------------------------------------------------------
	// s5: numerators for pos, vel, acc
	// ------------------------------------------------------------------
	logic               vld_s5;
	logic               err_s5;
	logic signed [BW-1:0] base_s5;
	logic signed [NW-1:0] n_s5 [0:NRES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			err_s5  <= err_s4;
			base_s5 <= base_s4;
			for (int k = 0; k < NRES; k++) begin
				n_s5[k] <= term_s4[2*k] + term_s4[2*k+1];
			end
		end
	end

	// ------------------------------------------------------------------
	// s6: magnitude plus half divisor (round half away from zero)
	// ------------------------------------------------------------------
	logic               vld_s6;
	sband_t             sb_s6;
	logic [NMW-1:0]     mag_s6 [0:NRES-1];
	logic [NMW-1:0]     mag_d  [0:NRES-1];
	logic [NRES-1:0]    neg_d;

	always_comb begin
		for (int k = 0; k < NRES; k++) begin
			neg_d[k] = n_s5[k][NW-1];
			mag_d[k] = (neg_d[k] ? NMW'(-n_s5[k]) : NMW'(n_s5[k])) + NMW'(t3_q >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6.err  <= err_s5;
			sb_s6.neg  <= neg_d;
			sb_s6.base <= base_s5;
			for (int k = 0; k < NRES; k++) begin
				mag_s6[k] <= mag_d[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Dividers by T^3; quotient >= 2^QW saturates the result anyway
	// ------------------------------------------------------------------
	logic [QW-1:0]   quo [0:NRES-1];
	logic [NRES-1:0] qsat;

	for (genvar k = 0; k < NRES; k++) begin : g_div
		chse_div #(
			.NUM_W (NMW),
			.DEN_W (DW),
			.QUO_W (QW)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (mag_s6[k]),
			.den (t3_q),
			.quo (quo[k]),
			.sat (qsat[k])
		);
	end

	// sideband line alongside the dividers
	sband_t sb_d  [0:DIV_LAT-1];
	logic   vld_d [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_d[0] <= sb_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				sb_d[i] <= sb_d[i-1];
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_d[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vld_d[0] <= vld_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
			out_valid_q <= vld_d[DIV_LAT-1];
		end
	end

	// ------------------------------------------------------------------
	// Output stage: sign, clamp, add base terms, saturate
	// ------------------------------------------------------------------
	sband_t sbo;
	logic signed [QW+1:0] qs [0:NRES-1];
	logic [QW:0]          qa;
	logic signed [VAL_W-1:0] pos_d, vel_d, acc_d;
	logic signed [VAL_W-1:0] pos_q, vel_q, acc_q;
	logic                    err_q;

	assign sbo = sb_d[DIV_LAT-1];

	always_comb begin
		qa = '0;
		for (int k = 0; k < NRES; k++) begin
			qa    = qsat[k] ? ((QW+1)'(1) << QW) : {1'b0, quo[k]};
			qs[k] = sbo.neg[k] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
		end
		if (sbo.err) begin
			pos_d = '0;
			vel_d = '0;
			acc_d = '0;
		end else begin
			pos_d = sat32(RW'(sbo.base) + RW'(qs[0]));
			vel_d = sat32(RW'(sv_q) + RW'(qs[1]));
			acc_d = sat32(RW'(qs[2]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_q <= pos_d;
			vel_q <= vel_d;
			acc_q <= acc_d;
			err_q <= sbo.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_out    = pos_q;
	assign vel_out    = vel_q;
	assign acc_out    = acc_q;
	assign time_error = err_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_error |-> pos_out == '0 && vel_out == '0 && acc_out == '0)
		else $error("error result carries nonzero values");

	a_dur_nz: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> dur_q != '0)
		else $error("duration register holds zero");

	a_t3_nz: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> t3_q != '0)
		else $error("divisor is zero while an item reaches the divider");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s6) && $stable(out_valid_q))
		else $error("pipeline moved while held");

endmodule
`default_nettype wire

// ===== tb/cubic_hermite_segment_eval_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_hermite_segment_eval_top_tb
// Self-checking bench for the Hermite segment evaluator. Segment registers are
// loaded between phases while the block is idle. Local times go in through a
// valid/stall request channel with random gaps and random output stalls; every
// result is compared with a typed row or an in-bench fixed-point segment model.
// ----------------------------------------------------------------------------
module cubic_hermite_segment_eval_top_tb;
	import chse_pkg::*;

	// indexes past the last register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int DRAIN_CYCLES = 70;  // longer than the pipeline takes from request to result
	localparam int SETTLE_CYCLES = 4;  // lets T^3 settle through t2_q and t3_q after a write
	localparam int RAND_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct {
		logic signed [VAL_W-1:0] pos;
		logic signed [VAL_W-1:0] vel;
		logic signed [VAL_W-1:0] acc;
		logic                    err;
	} sample_t;

	typedef struct {
		logic signed [T_W-1:0] t;
		bit                    typed;  // expectation written in the row
		sample_t               want;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [T_W-1:0]    t_local;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [VAL_W-1:0]  pos_out;
	logic signed [VAL_W-1:0]  vel_out;
	logic signed [VAL_W-1:0]  acc_out;
	logic                     time_error;

	cubic_hermite_segment_eval_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .t_local(t_local),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_out(pos_out), .vel_out(vel_out), .acc_out(acc_out),
		.time_error(time_error)
	);

	// segment model state
	longint seg_p0, seg_v0, seg_p1, seg_v1, seg_dur, seg_quad, seg_cubic;

	sample_t pending_samples[$];
	int      mismatches;
	int      stray_results;
	bit      calm_phase;  // no gaps on either side while set

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// segment model
	// ------------------------------------------------------------------
	function automatic void rederive_coeffs();
		longint d;
		d = seg_p0 - seg_p1;
		seg_quad  = -(3 * d + seg_dur * (2 * seg_v0 + seg_v1));
		seg_cubic = 2 * d + seg_dur * (seg_v0 + seg_v1);
	endfunction

	// round to nearest, ties away from zero, clamp magnitude to 2^62
	function automatic logic signed [159:0] div_nearest(input logic signed [159:0] n,
			input logic signed [159:0] d);
		logic [159:0] mag;
		logic [159:0] q;
		mag = (n < 0) ? -n : n;
		q = (mag + (d >>> 1)) / d;
		if (q > (160'd1 << 62))
			q = 160'd1 << 62;
		return (n < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp32(input logic signed [159:0] v);
		if (v > 160'sd2147483647)
			return 32'sh7fffffff;
		if (v < -160'sd2147483648)
			return 32'sh80000000;
		return v[VAL_W-1:0];
	endfunction

	function automatic sample_t eval_segment(input logic signed [T_W-1:0] t);
		sample_t r;
		logic signed [159:0] tt, dd, d3, qc, kc, n;
		r = '{pos: '0, vel: '0, acc: '0, err: 1'b1};
		if (t < 0)
			return r;
		tt = t;
		dd = seg_dur;
		d3 = dd * dd * dd;
		qc = seg_quad;
		kc = seg_cubic;
		n = qc * tt * tt * dd + kc * tt * tt * tt;
		r.pos = clamp32(160'(seg_p0) + 160'(seg_v0) * tt + div_nearest(n, d3));
		n = 2 * qc * tt * dd + 3 * kc * tt * tt;
		r.vel = clamp32(160'(seg_v0) + div_nearest(n, d3));
		n = 2 * qc * dd + 6 * kc * tt;
		r.acc = clamp32(div_nearest(n, d3));
		r.err = 1'b0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// register writes and requests
	// ------------------------------------------------------------------
	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_START_POS: seg_p0 = longint'($signed(val));
			REG_START_VEL: seg_v0 = longint'($signed(val));
			REG_END_POS:   seg_p1 = longint'($signed(val));
			REG_END_VEL:   seg_v1 = longint'($signed(val));
			REG_DURATION:  seg_dur = (val[15:0] == 16'd0) ? 1 : longint'(val[15:0]);
			default: return;
		endcase
		rederive_coeffs();
	endtask

	task automatic load_segment(input logic [31:0] p0, input logic [31:0] v0,
			input logic [31:0] p1, input logic [31:0] v1, input logic [31:0] dur);
		write_reg(REG_START_POS, p0);
		write_reg(REG_START_VEL, v0);
		write_reg(REG_END_POS, p1);
		write_reg(REG_END_VEL, v1);
		write_reg(REG_DURATION, dur);
		cfg_we <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_gap();
		if (calm_phase || $urandom_range(0, 9) < 6)
			return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// offer one request, hold it until taken, then log what it should produce
	task automatic send_time(input logic signed [T_W-1:0] t, input bit typed,
			input sample_t want);
		int gap;
		sample_t exp_res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		t_local  <= t;
		do @(posedge clk); while (in_stall);
		exp_res = typed ? want : eval_segment(t);
		pending_samples.insert(pending_samples.size(), exp_res);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			3: return $urandom_range(0, 65535) - 32768;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_duration();
		case ($urandom_range(0, 5))
			0: return 1;
			1: return 65535;
			2: return $urandom_range(1, 1000);
			3: return {16'($urandom_range(0, 65535)), 16'($urandom)};  // upper bits dropped
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	// mostly inside the segment, some past its end, some negative, some raw
	function automatic logic signed [T_W-1:0] rand_time();
		int lim;
		lim = (seg_dur > 65535) ? 65535 : int'(seg_dur);
		case ($urandom_range(0, 9))
			0: return -$signed(T_W'($urandom_range(1, 65536)));
			1: return T_W'($urandom);
			2: return T_W'($urandom_range(lim, 65535));
			3: return T_W'(lim);
			default: return T_W'($urandom_range(0, lim));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				stray_results++;
				if (mismatches + stray_results <= 10)
					$display("unexpected result pos=%0d vel=%0d acc=%0d err=%0b",
						pos_out, vel_out, acc_out, time_error);
			end else begin
				want = pending_samples.pop_front();
				if (pos_out !== want.pos || vel_out !== want.vel || acc_out !== want.acc
						|| time_error !== want.err) begin
					mismatches++;
					if (mismatches + stray_results <= 10)
						$display("mismatch exp pos=%0d vel=%0d acc=%0d err=%0b got pos=%0d vel=%0d acc=%0d err=%0b",
							want.pos, want.vel, want.acc, want.err,
							pos_out, vel_out, acc_out, time_error);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls, plus one long hold-off so the pipe backs up
	// ------------------------------------------------------------------
	initial begin
		int cycles;
		int n;
		bit held;
		cycles = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			if (!held && cycles > 3000) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				cycles += 400;
			end
			out_stall <= 1'b0;
			n = $urandom_range(1, 12);
			repeat (n) @(posedge clk);
			cycles += n;
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				cycles += n;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		stim_row_t rows[$];
		sample_t zero_res, err_res, dummy;
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		t_local = '0;
		mismatches = 0;
		stray_results = 0;
		calm_phase = 1'b0;
		seg_p0 = 0; seg_v0 = 0; seg_p1 = 0; seg_v1 = 0; seg_dur = 1;
		seg_quad = 0; seg_cubic = 0;
		zero_res = '{pos: '0, vel: '0, acc: '0, err: 1'b0};
		err_res  = '{pos: '0, vel: '0, acc: '0, err: 1'b1};
		dummy = zero_res;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the segment is flat at zero; negative time flags an error
		rows = '{
			'{t: 17'sd0,      typed: 1, want: zero_res},
			'{t: 17'sd65535,  typed: 1, want: zero_res},
			'{t: -17'sd1,     typed: 1, want: err_res},
			'{t: -17'sd65536, typed: 1, want: err_res},
			'{t: 17'sd1,      typed: 1, want: zero_res}
		};
		foreach (rows[i])
			send_time(rows[i].t, rows[i].typed, rows[i].want);
		drain();

		// extreme nodes over the longest segment
		load_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'd65535);
		rows = '{
			'{t: 17'sd0,      typed: 0, want: dummy},
			'{t: 17'sd1,      typed: 0, want: dummy},
			'{t: 17'sd32768,  typed: 0, want: dummy},
			'{t: 17'sd65535,  typed: 0, want: dummy},
			'{t: -17'sd65536, typed: 1, want: err_res}
		};
		foreach (rows[i])
			send_time(rows[i].t, rows[i].typed, rows[i].want);
		drain();

		// shortest segment, opposite extremes, sampled far past its end
		load_segment(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'd1);
		rows = '{
			'{t: 17'sd0,     typed: 0, want: dummy},
			'{t: 17'sd1,     typed: 0, want: dummy},
			'{t: 17'sd2,     typed: 0, want: dummy},
			'{t: 17'sd65535, typed: 0, want: dummy},
			'{t: -17'sd2,    typed: 1, want: err_res}
		};
		foreach (rows[i])
			send_time(rows[i].t, rows[i].typed, rows[i].want);
		drain();

		// a zero duration acts as one; spare indexes must not touch anything
		load_segment(32'h00010000, 32'h00000800, 32'h00050000, 32'hfffff000, 32'd0);
		write_reg(REG_SPARE_LO, 32'hdeadbeef);
		write_reg(REG_SPARE_HI, 32'h12345678);
		cfg_we <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		rows = '{
			'{t: 17'sd0,   typed: 0, want: dummy},
			'{t: 17'sd1,   typed: 0, want: dummy},
			'{t: 17'sd3,   typed: 0, want: dummy},
			'{t: 17'sd100, typed: 0, want: dummy}
		};
		foreach (rows[i])
			send_time(rows[i].t, rows[i].typed, rows[i].want);
		drain();

		// random segments, every third phase without any idling
		for (p = 0; p < RAND_PHASES; p++) begin
			load_segment(rand_word(), rand_word(), rand_word(), rand_word(), rand_duration());
			calm_phase = (p % 3 == 1);
			repeat (ITEMS_PER_PHASE)
				send_time(rand_time(), 1'b0, dummy);
			drain();
		end
		calm_phase = 1'b0;

		if (mismatches == 0 && stray_results == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/chse_pkg.sv
hw/rtl/chse_div.sv
hw/rtl/cubic_hermite_segment_eval_top.sv
tb/cubic_hermite_segment_eval_top_tb.sv
